[src/lrdc_pkg.sv]
// Shared types, widths and constants for the laser reactive drive controller.
`default_nettype none

package lrdc_pkg;

  localparam int MAX_BEAMS = 1024;
  localparam int BEAM_W = $clog2(MAX_BEAMS);
  // clamped scan length must hold both the register value and MAX_BEAMS
  localparam int N_W = (BEAM_W + 1 > 11) ? BEAM_W + 1 : 11;

  localparam int DIST_W = 14;
  localparam int SUM_W = 24;
  localparam int SCAN_W = 11;
  localparam int SECT_W = 9;
  localparam int SPEED_W = 11;
  localparam int BAND_W = 12;
  localparam int ROT_W = 5;
  localparam int STUCK_W = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 14;
  localparam int WIDE_W = SUM_W + N_W;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [SPEED_W-1:0] speed_t;
  typedef logic signed [ROT_W-1:0] rot_t;
  typedef logic [STUCK_W-1:0] stuck_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [N_W-1:0] len_t;
  typedef logic [WIDE_W-1:0] wide_t;

  typedef enum logic [1:0] {
    MODE_ADVANCE = 2'd0,
    MODE_WALL    = 2'd1,
    MODE_SPIRAL  = 2'd2,
    MODE_ROTATE  = 2'd3
  } mode_t;

  // configuration register indexes
  localparam cfg_idx_t REG_SCAN_POINTS   = 3'd0;
  localparam cfg_idx_t REG_SECTOR_LEN    = 3'd1;
  localparam cfg_idx_t REG_MAX_SPEED     = 3'd2;
  localparam cfg_idx_t REG_WALL_DISTANCE = 3'd3;
  localparam cfg_idx_t REG_WALL_BAND     = 3'd4;
  localparam cfg_idx_t REG_START_MODE    = 3'd5;

  // register reset values
  localparam logic [SCAN_W-1:0] SCAN_POINTS_RST = 11'd100;
  localparam logic [SECT_W-1:0] SECTOR_LEN_RST  = 9'd33;
  localparam speed_t MAX_SPEED_RST              = 11'd1000;
  localparam dist_t WALL_DISTANCE_RST           = 14'd500;
  localparam logic [BAND_W-1:0] WALL_BAND_RST   = 12'd100;

  localparam dist_t DIST_MAX = 14'h3FFF;
  localparam sum_t SUM_CAP = 24'hFFFFFF;
  localparam speed_t SPEED_CAP = 11'd2047;

  // decision thresholds and steps
  localparam dist_t OBSTACLE_MM   = 14'd1500;
  localparam dist_t WALL_EXIT_MM  = 14'd1000;
  localparam dist_t SPIRAL_MIN_MM = 14'd400;
  localparam stuck_t STUCK_LIMIT  = 7'd100;
  localparam speed_t ADV_STEP     = 11'd40;
  localparam speed_t SPIRAL_TOP   = 11'd800;
  localparam speed_t SPIRAL_STEP  = 11'd5;

  // rotation commands, quarter rad/s
  localparam rot_t ROT_TURN   = 5'sd2;
  localparam rot_t ROT_ESCAPE = 5'sd13;
  localparam rot_t ROT_WALL   = 5'sd1;
  localparam rot_t ROT_SPIRAL = 5'sd5;

endpackage

`default_nettype wire

[src/lrdc_if.sv]
// Valid/ready channel interfaces: beam input, result output and config writes.
`default_nettype none

interface lrdc_beam_if;
  import lrdc_pkg::*;
  logic valid;
  logic ready;
  dist_t distance;
  modport source(output valid, output distance, input ready);
  modport sink(input valid, input distance, output ready);
endinterface

interface lrdc_result_if;
  import lrdc_pkg::*;
  logic valid;
  logic ready;
  speed_t advance_speed;
  rot_t rotation_quarters;
  mode_t mode_now;
  modport source(output valid, output advance_speed, output rotation_quarters,
                 output mode_now, input ready);
  modport sink(input valid, input advance_speed, input rotation_quarters,
               input mode_now, output ready);
endinterface

interface lrdc_cfg_if;
  import lrdc_pkg::*;
  logic valid;
  logic ready;
  cfg_idx_t index;
  cfg_data_t data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/laser_reactive_drive_controller_unit.sv]
// Top level: per-beam sector accumulation and end-of-scan drive decision.
`default_nettype none

// Takes one beam range per clock unless stalled and emits one drive request
// per scan, after the last beam. The beam path is a four-deep pipeline: input
// register, sector accumulators (centre minimum, saturating side sums), a
// product stage that cross-multiplies the side sums with the sector counts and
// forms the wall band limits, and the decision logic that updates speed,
// rotation, the stuck counter and the mode into the output register. A beam is
// accepted every cycle unless stalled; after its last beam, a scan's result
// passes the snapshot, product and output registers. With the output stalled,
// two more scans' worth of work can be parked in the pipeline before beam
// intake stops. Configuration is taken at any time and must only be written
// while the block is idle; writing start_mode also loads the current mode.
module laser_reactive_drive_controller_unit (
  input  logic clk,
  input  logic rst,
  lrdc_cfg_if.sink      cfg,
  lrdc_beam_if.sink     beam,
  lrdc_result_if.source result
);
  import lrdc_pkg::*;

  // configuration
  logic [SCAN_W-1:0] scan_points;
  logic [SECT_W-1:0] sector_len;
  speed_t            max_speed;
  dist_t             wall_distance;
  logic [BAND_W-1:0] wall_band;

  // input register
  logic  a_valid;
  dist_t a_dist;
  logic  a_adv, a_free;

  // accumulators
  logic [BEAM_W-1:0] beam_index;
  dist_t centre_min, centre_min_next;
  sum_t  left_sum, right_sum, left_sum_next, right_sum_next;

  // clamped geometry
  len_t  n_len, s_lo, s_max, s_len, two_s, lc, i_ext;
  logic  last_beam, in_right, in_centre, in_left;
  logic [SUM_W:0] right_add, left_add;

  // snapshot stage
  logic  s_valid, s_adv, s_free;
  sum_t  s_right, s_left;
  dist_t s_cmin;
  len_t  s_lc;
  logic [SECT_W-1:0] s_rc;

  // product stage
  logic  p_valid, p_adv;
  wide_t p_prod_r, p_prod_l, p_hi, p_lo;
  logic  p_lo_ok;
  sum_t  p_left;
  dist_t p_cmin;
  logic [DIST_W:0] band_hi;

  // decision state
  speed_t advance_now, advance_next;
  rot_t   rotation_now, rotation_next;
  stuck_t stuck_count, stuck_next;
  mode_t  mode, mode_next;
  logic   right_not_above, left_off_band;
  logic [SPEED_W:0] adv_sum;

  logic out_valid, out_free;
  logic cfg_write;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_points   <= SCAN_POINTS_RST;
      sector_len    <= SECTOR_LEN_RST;
      max_speed     <= MAX_SPEED_RST;
      wall_distance <= WALL_DISTANCE_RST;
      wall_band     <= WALL_BAND_RST;
    end else if (cfg_write) begin
      case (cfg.index)
        REG_SCAN_POINTS:   scan_points   <= cfg.data[SCAN_W-1:0];
        REG_SECTOR_LEN:    sector_len    <= cfg.data[SECT_W-1:0];
        REG_MAX_SPEED:     max_speed     <= cfg.data[SPEED_W-1:0];
        REG_WALL_DISTANCE: wall_distance <= cfg.data[DIST_W-1:0];
        REG_WALL_BAND:     wall_band     <= cfg.data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake chain, back to front
  assign out_free  = !out_valid || result.ready;
  assign p_adv     = p_valid && out_free;
  assign s_adv     = s_valid && (!p_valid || p_adv);
  assign s_free    = !s_valid || s_adv;
  assign a_adv     = a_valid && s_free;
  assign a_free    = !a_valid || a_adv;
  assign beam.ready = a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= beam.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (beam.valid && a_free) begin
      a_dist <= beam.distance;
    end
  end

  // scan length held to 3..MAX_BEAMS, sector length to 1..(n-1)/2
  always_comb begin
    if (N_W'(scan_points) < N_W'(3)) begin
      n_len = N_W'(3);
    end else if (N_W'(scan_points) > N_W'(MAX_BEAMS)) begin
      n_len = N_W'(MAX_BEAMS);
    end else begin
      n_len = N_W'(scan_points);
    end
    s_lo  = (sector_len == '0) ? N_W'(1) : N_W'(sector_len);
    s_max = (n_len - N_W'(1)) >> 1;
    s_len = (s_lo > s_max) ? s_max : s_lo;
    two_s = s_len << 1;
    lc    = n_len - two_s;
    i_ext = N_W'(beam_index);

    last_beam = i_ext >= n_len - N_W'(1);
    in_right  = i_ext < s_len;
    in_centre = (i_ext >= s_len) && (i_ext < n_len - s_len);
    in_left   = i_ext >= two_s;

    right_add = {1'b0, right_sum} + (SUM_W+1)'(a_dist);
    left_add  = {1'b0, left_sum} + (SUM_W+1)'(a_dist);

    right_sum_next = right_sum;
    if (in_right) begin
      right_sum_next = right_add[SUM_W] ? SUM_CAP : right_add[SUM_W-1:0];
    end
    left_sum_next = left_sum;
    if (in_left) begin
      left_sum_next = left_add[SUM_W] ? SUM_CAP : left_add[SUM_W-1:0];
    end
    centre_min_next = (in_centre && a_dist < centre_min) ? a_dist : centre_min;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_index <= '0;
      centre_min <= DIST_MAX;
      left_sum   <= '0;
      right_sum  <= '0;
    end else if (a_adv) begin
      if (last_beam) begin
        beam_index <= '0;
        centre_min <= DIST_MAX;
        left_sum   <= '0;
        right_sum  <= '0;
      end else begin
        beam_index <= beam_index + BEAM_W'(1);
        centre_min <= centre_min_next;
        left_sum   <= left_sum_next;
        right_sum  <= right_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (a_adv && last_beam) begin
      s_valid <= 1'b1;
    end else if (s_adv) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && last_beam) begin
      s_right <= right_sum_next;
      s_left  <= left_sum_next;
      s_cmin  <= centre_min_next;
      s_lc    <= lc;
      s_rc    <= s_len[SECT_W-1:0];
    end
  end

  assign band_hi = {1'b0, wall_distance} + (DIST_W+1)'(wall_band);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (s_adv) begin
      p_valid <= 1'b1;
    end else if (p_adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv) begin
      p_prod_r <= WIDE_W'(s_right) * WIDE_W'(s_lc);
      p_prod_l <= WIDE_W'(s_left) * WIDE_W'(s_rc);
      p_hi     <= WIDE_W'(band_hi) * WIDE_W'(s_lc);
      p_lo     <= WIDE_W'(wall_distance - DIST_W'(wall_band)) * WIDE_W'(s_lc);
      p_lo_ok  <= DIST_W'(wall_band) <= wall_distance && BAND_W <= DIST_W;
      p_left   <= s_left;
      p_cmin   <= s_cmin;
    end
  end

  always_comb begin
    right_not_above = p_prod_r <= p_prod_l;
    left_off_band   = (WIDE_W'(p_left) > p_hi) ||
                      (p_lo_ok && WIDE_W'(p_left) < p_lo);
    advance_next  = advance_now;
    rotation_next = rotation_now;
    stuck_next    = stuck_count;
    mode_next     = mode;
    adv_sum       = {1'b0, advance_now} + {1'b0, ADV_STEP};
    case (mode)
      MODE_ADVANCE: begin
        if (p_cmin <= OBSTACLE_MM) begin
          if (stuck_count < STUCK_LIMIT) begin
            stuck_next    = stuck_count + STUCK_W'(1);
            rotation_next = right_not_above ? -ROT_TURN : ROT_TURN;
          end else begin
            rotation_next = right_not_above ? -ROT_ESCAPE : ROT_ESCAPE;
            stuck_next    = '0;
          end
          advance_next = '0;
        end else if (advance_now < max_speed) begin
          advance_next  = (adv_sum > {1'b0, SPEED_CAP}) ? SPEED_CAP
                                                        : adv_sum[SPEED_W-1:0];
          rotation_next = '0;
        end
      end
      MODE_WALL: begin
        if (p_cmin < WALL_EXIT_MM) begin
          mode_next = MODE_ADVANCE;
        end else begin
          advance_next  = max_speed;
          rotation_next = left_off_band ? ROT_WALL : '0;
        end
      end
      MODE_SPIRAL: begin
        if (p_cmin >= SPIRAL_MIN_MM) begin
          rotation_next = ROT_SPIRAL;
          if (advance_now < SPIRAL_TOP) begin
            advance_next = advance_now + SPIRAL_STEP;
          end else begin
            mode_next = MODE_ADVANCE;
          end
        end else begin
          mode_next = MODE_ADVANCE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      advance_now  <= '0;
      rotation_now <= '0;
      stuck_count  <= '0;
      mode         <= MODE_ADVANCE;
    end else if (cfg_write && cfg.index == REG_START_MODE) begin
      mode <= mode_t'(cfg.data[1:0]);
    end else if (p_adv) begin
      advance_now  <= advance_next;
      rotation_now <= rotation_next;
      stuck_count  <= stuck_next;
      mode         <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // decision state only moves on p_adv, which waits for the output slot, or on a start_mode write
  assign result.valid             = out_valid;
  assign result.advance_speed     = advance_now;
  assign result.rotation_quarters = rotation_now;
  assign result.mode_now          = mode;

`ifndef SYNTHESIS
  a_stuck_bound: assert property (@(posedge clk) disable iff (rst)
    stuck_count <= STUCK_LIMIT)
    else $error("stuck counter past its limit");

  a_snap_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(s_valid) |-> $past(a_adv && last_beam))
    else $error("scan snapshot without a last beam");

  a_scan_restart: assert property (@(posedge clk) disable iff (rst)
    a_adv && last_beam |=> centre_min == DIST_MAX && beam_index == '0)
    else $error("accumulators not cleared at scan end");

  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rotation_now <= ROT_ESCAPE && rotation_now >= -ROT_ESCAPE)
    else $error("rotation request out of range");

  a_spiral_exit: assert property (@(posedge clk) disable iff (rst)
    p_adv && mode == MODE_SPIRAL && !cfg_write |=>
      mode == MODE_SPIRAL || mode == MODE_ADVANCE)
    else $error("spiral left to a mode other than advance");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
// Testbench for the laser drive controller: directed scans, then random scans against a predictor.
module testbench;
  import lrdc_pkg::*;

  localparam int SETTLE = 6;          // pipeline depth plus margin
  localparam int HOLD_CYCLES = 300;   // long output stall, fills the pipeline
  localparam cfg_idx_t REG_SPARE = 3'd7;  // unmapped index, write has no effect

  typedef struct packed {
    speed_t adv;
    rot_t turn;
    mode_t md;
  } drive_t;

  typedef enum bit {ROW_WRITE, ROW_BEAM} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    cfg_idx_t idx;
    cfg_data_t val;
    bit pinned;
    drive_t fixed;
  } row_t;

  typedef enum logic [2:0] {
    MIX_ANY, MIX_NEAR, MIX_FAR, MIX_MID, MIX_EDGE, MIX_WALL
  } dist_mix_t;

  logic clk = 1'b0;
  logic rst;

  lrdc_cfg_if cfg_bus();
  lrdc_beam_if beam_bus();
  lrdc_result_if drive_bus();

  laser_reactive_drive_controller_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .beam(beam_bus),
    .result(drive_bus)
  );

  always #1 clk = ~clk;

  // register mirror
  int unsigned reg_scan, reg_sector, reg_max_speed, reg_wall_dist, reg_wall_band;

  // scan accumulators and drive state
  int unsigned beam_pos, near_min, left_acc, right_acc, speed_now, stuck_now;
  rot_t turn_now;
  mode_t mode_q;

  drive_t pending_drive[$];
  drive_t pinned_drive;
  bit pinned_armed = 1'b0;
  row_t plan[$];

  int unsigned beams_fed = 0;
  int unsigned faults = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  function automatic int unsigned scan_len();
    int unsigned n;
    n = reg_scan;
    if (n < 3) n = 3;
    if (n > MAX_BEAMS) n = MAX_BEAMS;
    return n;
  endfunction

  // Folds one beam into the scan; returns 1 with the drive request at the end of a scan.
  function automatic bit next_drive(input dist_t d, output drive_t cmd);
    int unsigned n, s, i, lc;
    longint hi, lo;
    bit right_low;
    n = scan_len();
    s = reg_sector;
    i = beam_pos;
    cmd = '0;
    if (s < 1) s = 1;
    if (s > (n - 1) / 2) s = (n - 1) / 2;

    if (i < s) right_acc = (right_acc + d > SUM_CAP) ? SUM_CAP : right_acc + d;
    if (i >= s && i < n - s && d < near_min) near_min = d;
    if (i >= 2 * s) left_acc = (left_acc + d > SUM_CAP) ? SUM_CAP : left_acc + d;

    if (i + 1 < n) begin
      beam_pos = i + 1;
      return 1'b0;
    end

    lc = n - 2 * s;
    // compare means without dividing
    right_low = longint'(right_acc) * longint'(lc) <= longint'(left_acc) * longint'(s);
    case (mode_q)
      MODE_ADVANCE: begin
        if (near_min <= OBSTACLE_MM) begin
          if (stuck_now < STUCK_LIMIT) begin
            stuck_now++;
            turn_now = right_low ? -ROT_TURN : ROT_TURN;
          end else begin
            turn_now = right_low ? -ROT_ESCAPE : ROT_ESCAPE;
            stuck_now = 0;
          end
          speed_now = 0;
        end else if (speed_now < reg_max_speed) begin
          speed_now = speed_now + ADV_STEP;
          if (speed_now > SPEED_CAP) speed_now = SPEED_CAP;
          turn_now = '0;
        end
      end
      MODE_WALL: begin
        if (near_min < WALL_EXIT_MM) begin
          mode_q = MODE_ADVANCE;
        end else begin
          hi = (longint'(reg_wall_dist) + longint'(reg_wall_band)) * longint'(lc);
          lo = (longint'(reg_wall_dist) - longint'(reg_wall_band)) * longint'(lc);
          speed_now = reg_max_speed;
          turn_now = (longint'(left_acc) > hi || longint'(left_acc) < lo) ? ROT_WALL : '0;
        end
      end
      MODE_SPIRAL: begin
        if (near_min >= SPIRAL_MIN_MM) begin
          turn_now = ROT_SPIRAL;
          if (speed_now < SPIRAL_TOP) speed_now = speed_now + SPIRAL_STEP;
          else mode_q = MODE_ADVANCE;
        end else begin
          mode_q = MODE_ADVANCE;
        end
      end
      default: ;
    endcase

    beam_pos = 0;
    near_min = DIST_MAX;
    left_acc = 0;
    right_acc = 0;
    cmd.adv = speed_t'(speed_now);
    cmd.turn = turn_now;
    cmd.md = mode_q;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : scoreboard
    drive_t fresh, want;
    if (rst) begin
      reg_scan = SCAN_POINTS_RST;
      reg_sector = SECTOR_LEN_RST;
      reg_max_speed = MAX_SPEED_RST;
      reg_wall_dist = WALL_DISTANCE_RST;
      reg_wall_band = WALL_BAND_RST;
      mode_q = MODE_ADVANCE;
      beam_pos = 0;
      near_min = DIST_MAX;
      left_acc = 0;
      right_acc = 0;
      speed_now = 0;
      stuck_now = 0;
      turn_now = '0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_SCAN_POINTS: reg_scan = cfg_bus.data & 14'h7FF;
          REG_SECTOR_LEN: reg_sector = cfg_bus.data & 14'h1FF;
          REG_MAX_SPEED: reg_max_speed = cfg_bus.data & 14'h7FF;
          REG_WALL_DISTANCE: reg_wall_dist = cfg_bus.data;
          REG_WALL_BAND: reg_wall_band = cfg_bus.data & 14'hFFF;
          REG_START_MODE: mode_q = mode_t'(cfg_bus.data[1:0]);
          default: ;
        endcase
      end
      if (beam_bus.valid && beam_bus.ready && next_drive(beam_bus.distance, fresh)) begin
        if (pinned_armed) begin
          pending_drive.push_back(pinned_drive);
          pinned_armed = 1'b0;
        end else begin
          pending_drive.push_back(fresh);
        end
      end
      if (drive_bus.valid && drive_bus.ready) begin
        if (pending_drive.size() == 0) begin
          $display("%0t: drive request with none expected: speed %0d rot %0d mode %0d",
                   $time, drive_bus.advance_speed, $signed(drive_bus.rotation_quarters),
                   drive_bus.mode_now);
          faults++;
        end else begin
          want = pending_drive.pop_front();
          if (drive_bus.advance_speed !== want.adv) begin
            $display("%0t: advance_speed expected %0d, got %0d",
                     $time, want.adv, drive_bus.advance_speed);
            faults++;
          end
          if (drive_bus.rotation_quarters !== want.turn) begin
            $display("%0t: rotation_quarters expected %0d, got %0d",
                     $time, $signed(want.turn), $signed(drive_bus.rotation_quarters));
            faults++;
          end
          if (drive_bus.mode_now !== want.md) begin
            $display("%0t: mode_now expected %0d, got %0d",
                     $time, want.md, drive_bus.mode_now);
            faults++;
          end
        end
      end
    end
  end

  function automatic void push_write(input cfg_idx_t idx, input cfg_data_t v);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.val = v;
    plan.push_back(r);
  endfunction

  // three-beam scan; the drive request is typed in on the last beam
  function automatic void push_scan(input dist_t a, input dist_t b, input dist_t c,
                                    input speed_t adv, input rot_t turn, input mode_t md);
    row_t r;
    r = '0;
    r.kind = ROW_BEAM;
    r.val = a;
    plan.push_back(r);
    r.val = b;
    plan.push_back(r);
    r.val = c;
    r.pinned = 1'b1;
    r.fixed.adv = adv;
    r.fixed.turn = turn;
    r.fixed.md = md;
    plan.push_back(r);
  endfunction

  function automatic dist_t draw_dist(input dist_mix_t mix);
    int c;
    case (mix)
      MIX_NEAR: return dist_t'($urandom_range(0, 1600));
      MIX_FAR: return dist_t'($urandom_range(1501, DIST_MAX));
      MIX_MID: return dist_t'($urandom_range(300, 1200));
      MIX_EDGE: return $urandom_range(0, 1) ? DIST_MAX : '0;
      MIX_WALL: begin
        c = int'(reg_wall_dist) + int'($urandom_range(0, 2 * reg_wall_band + 2))
            - int'(reg_wall_band) - 1;
        if (c < 0) c = 0;
        if (c > DIST_MAX) c = DIST_MAX;
        return dist_t'(c);
      end
      default: return dist_t'($urandom_range(0, DIST_MAX));
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_beam(input dist_t d);
    if (!calm && $urandom_range(0, 7) == 0) begin
      beam_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    beam_bus.valid <= 1'b1;
    beam_bus.distance <= d;
    @(posedge clk);
    while (!beam_bus.ready) @(posedge clk);
    @(negedge clk);
    beams_fed++;
  endtask

  // registers change only with the pipeline drained
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t v);
    beam_bus.valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : sink_side
    drive_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        drive_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        drive_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        drive_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned ph, count, n_now, v, pick;
    int big_left;
    dist_mix_t mix;
    big_left = 2;
    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    beam_bus.valid = 1'b0;
    beam_bus.distance = '0;

    push_write(REG_SPARE, 14'h3FFF);
    push_write(REG_SCAN_POINTS, 14'd3);
    push_write(REG_SECTOR_LEN, 14'd0);           // clamps to one beam per side
    push_scan(DIST_MAX, DIST_MAX, DIST_MAX, 11'd40, 5'sd0, MODE_ADVANCE);
    push_scan(14'd0, 14'd0, 14'd0, 11'd0, -5'sd2, MODE_ADVANCE);
    push_scan(DIST_MAX, 14'd0, 14'd0, 11'd0, 5'sd2, MODE_ADVANCE);
    push_write(REG_START_MODE, cfg_data_t'(MODE_SPIRAL));
    push_scan(14'd0, 14'd400, 14'd0, 11'd5, 5'sd5, MODE_SPIRAL);
    push_scan(14'd0, 14'd399, 14'd0, 11'd5, 5'sd5, MODE_ADVANCE);
    push_write(REG_START_MODE, cfg_data_t'(MODE_WALL));
    push_write(REG_WALL_DISTANCE, DIST_MAX);
    push_write(REG_WALL_BAND, 14'd4095);
    push_scan(14'd0, 14'd1000, 14'd0, 11'd1000, 5'sd1, MODE_WALL);
    push_scan(14'd0, 14'd999, DIST_MAX, 11'd1000, 5'sd1, MODE_ADVANCE);
    push_write(REG_START_MODE, cfg_data_t'(MODE_ROTATE));
    push_scan(14'd1, 14'd2, 14'd3, 11'd1000, 5'sd1, MODE_ROTATE);
    push_write(REG_MAX_SPEED, 14'd0);
    push_write(REG_START_MODE, cfg_data_t'(MODE_ADVANCE));
    push_scan(DIST_MAX, DIST_MAX, DIST_MAX, 11'd1000, 5'sd1, MODE_ADVANCE);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        if (plan[k].pinned) begin
          pinned_drive = plan[k].fixed;
          pinned_armed = 1'b1;
        end
        send_beam(plan[k].val[DIST_W-1:0]);
      end
    end

    for (ph = 0; beams_fed < 1800; ph++) begin
      if (beams_fed >= 1650) calm = 1'b1;
      case (ph)
        1: begin
          // long run of blocked scans walks the stuck counter into an escape turn
          write_reg(REG_SCAN_POINTS, 14'd3);
          write_reg(REG_SECTOR_LEN, 14'd1);
          write_reg(REG_START_MODE, cfg_data_t'(MODE_ADVANCE));
          mix = MIX_NEAR;
          count = 3 * 110;
        end
        3: begin
          // clear path ramps advance up to the speed cap
          write_reg(REG_SCAN_POINTS, 14'd3);
          write_reg(REG_MAX_SPEED, cfg_data_t'(SPEED_CAP));
          write_reg(REG_START_MODE, cfg_data_t'(MODE_ADVANCE));
          mix = MIX_FAR;
          count = 3 * 60;
        end
        5: begin
          write_reg(REG_SCAN_POINTS, 14'd3);
          hold_off = 1'b1;
          mix = MIX_ANY;
          count = 3 * 40;
        end
        default: begin
          if ($urandom_range(0, 1)) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) v = $urandom_range(3, 24);
            else if (pick < 17) v = $urandom_range(0, 2);
            else if (pick == 17 && big_left > 0) begin
              v = $urandom_range(900, 2047);
              big_left--;
            end else v = $urandom_range(25, 120);
            write_reg(REG_SCAN_POINTS, cfg_data_t'(v | ($urandom << SCAN_W)));
          end
          if ($urandom_range(0, 1)) begin
            v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                            : $urandom_range(0, scan_len() / 2 + 1);
            write_reg(REG_SECTOR_LEN, cfg_data_t'(v | ($urandom << SECT_W)));
          end
          if ($urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, 3);
            v = (pick == 0) ? 0 : (pick == 1) ? SPEED_CAP :
                (pick == 2) ? $urandom_range(0, 2047) : $urandom_range(0, 2000);
            write_reg(REG_MAX_SPEED, cfg_data_t'(v | ($urandom << SPEED_W)));
          end
          if ($urandom_range(0, 2) == 0) begin
            v = $urandom_range(0, 1) ? $urandom_range(0, DIST_MAX) : $urandom_range(0, 2000);
            write_reg(REG_WALL_DISTANCE, cfg_data_t'(v));
          end
          if ($urandom_range(0, 2) == 0) begin
            v = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 300);
            write_reg(REG_WALL_BAND, cfg_data_t'(v | ($urandom << BAND_W)));
          end
          if ($urandom_range(0, 2) != 0)
            write_reg(REG_START_MODE, cfg_data_t'($urandom));
          mix = dist_mix_t'($urandom_range(0, 5));
          n_now = scan_len();
          count = n_now * ((n_now > 64) ? 1 : $urandom_range(1, 6));
          // partial scan: the next register writes land mid-scan
          if ($urandom_range(0, 4) == 0) count += $urandom_range(1, n_now - 1);
        end
      endcase
      repeat (count) send_beam(draw_dist(mix));
    end

    beam_bus.valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (faults == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin : watchdog
    #800000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[laser_reactive_drive_controller_unit.f]
src/lrdc_pkg.sv
src/lrdc_if.sv
src/laser_reactive_drive_controller_unit.sv
dv/testbench.sv
